[hw/rtl/pfss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pfss_pkg;

  // Depth of the run queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // All results caused by one text byte.
  typedef struct packed {
    logic       two;      // two words, else one
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic       hc0;      // first word carries a character
    logic       str_end;  // run closes the string
    logic       acc;      // string accepted (valid with str_end)
  } run_t;

endpackage

`default_nettype wire

[hw/rtl/pfss_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfss_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       text_byte,
  input  wire logic             take,
  output logic                  run_valid,
  output pfss_pkg::run_t        run
);
  import pfss_pkg::*;

  localparam logic [3:0] PH_TEXT  = 4'd0;
  localparam logic [3:0] PH_PCT   = 4'd1;
  localparam logic [3:0] PH_FLAGS = 4'd2;
  localparam logic [3:0] PH_WDIG  = 4'd3;
  localparam logic [3:0] PH_AFTW  = 4'd4;
  localparam logic [3:0] PH_PREC  = 4'd5;
  localparam logic [3:0] PH_PDIG  = 4'd6;
  localparam logic [3:0] PH_LEN   = 4'd7;
  localparam logic [3:0] PH_H     = 4'd8;
  localparam logic [3:0] PH_L     = 4'd9;
  localparam logic [3:0] PH_CONV  = 4'd10;

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic       rejected;
  logic       rejected_next;

  logic [3:0] adv_phase;
  logic [1:0] adv_n;
  logic [7:0] adv_ch0;
  logic [7:0] adv_ch1;
  logic       adv_rej;
  logic       is_end;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_flag(input logic [7:0] c);
    logic r;
    case (c) inside
      "-", "+", " ", "#", "0": r = 1'b1;
      default:                 r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_lenmod(input logic [7:0] c);
    logic r;
    case (c) inside
      "j", "z", "t", "L", "I", "w": r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_known(input logic [7:0] c);
    logic r;
    case (c) inside
      "d", "i", "o", "u", "x", "X", "f", "F", "e", "E",
      "g", "G", "a", "A", "c", "s", "p": r = 1'b1;
      default:                           r = 1'b0;
    endcase
    return r;
  endfunction

  assign is_end = (text_byte == 8'd0);

  // Phase step: each phase either settles or falls through to a later one.
  always_comb begin
    logic fall_flags;
    logic fall_aftw;
    logic fall_len;
    logic fall_conv;
    fall_flags = 1'b0;
    fall_aftw  = 1'b0;
    fall_len   = 1'b0;
    fall_conv  = 1'b0;
    adv_phase  = PH_TEXT;
    adv_n      = 2'd0;
    adv_ch0    = 8'd0;
    adv_ch1    = 8'd0;
    adv_rej    = 1'b0;

    unique case (phase)
      PH_PCT: begin
        if (text_byte != "%") fall_flags = 1'b1;
      end
      PH_FLAGS: fall_flags = 1'b1;
      PH_WDIG: begin
        if (is_digit(text_byte)) adv_phase = PH_WDIG;
        else fall_aftw = 1'b1;
      end
      PH_AFTW: fall_aftw = 1'b1;
      PH_PREC: begin
        if (text_byte == "*") begin
          adv_n = 2'd1; adv_ch0 = text_byte; adv_phase = PH_LEN;
        end else if (is_digit(text_byte)) begin
          adv_phase = PH_PDIG;
        end else begin
          fall_len = 1'b1;
        end
      end
      PH_PDIG: begin
        if (is_digit(text_byte)) adv_phase = PH_PDIG;
        else fall_len = 1'b1;
      end
      PH_LEN: fall_len = 1'b1;
      PH_H: begin
        if (text_byte == "h") begin
          adv_n = 2'd1; adv_ch0 = text_byte; adv_phase = PH_CONV;
        end else begin
          fall_conv = 1'b1;
        end
      end
      PH_L: begin
        if (text_byte == "l") begin
          adv_n = 2'd1; adv_ch0 = text_byte; adv_phase = PH_CONV;
        end else begin
          fall_conv = 1'b1;
        end
      end
      PH_CONV: fall_conv = 1'b1;
      default: adv_phase = (text_byte == "%") ? PH_PCT : PH_TEXT;
    endcase

    if (fall_flags) begin
      if (is_flag(text_byte)) begin
        adv_phase = PH_FLAGS;
      end else if (text_byte == "*") begin
        adv_n = 2'd1; adv_ch0 = text_byte; adv_phase = PH_AFTW;
      end else if (is_digit(text_byte)) begin
        adv_phase = PH_WDIG;
      end else begin
        fall_aftw = 1'b1;
      end
    end

    if (fall_aftw) begin
      if (text_byte == ".") adv_phase = PH_PREC;
      else fall_len = 1'b1;
    end

    if (fall_len) begin
      if (text_byte == "h") begin
        adv_n = 2'd1; adv_ch0 = text_byte; adv_phase = PH_H;
      end else if (text_byte == "l") begin
        adv_n = 2'd1; adv_ch0 = text_byte; adv_phase = PH_L;
      end else if (is_lenmod(text_byte)) begin
        adv_n = 2'd1; adv_ch0 = text_byte; adv_phase = PH_CONV;
      end else begin
        fall_conv = 1'b1;
      end
    end

    if (fall_conv) begin
      adv_phase = PH_TEXT;
      if (text_byte == "n") begin
        adv_rej = 1'b1;
      end else if (is_known(text_byte)) begin
        adv_n = 2'd2; adv_ch0 = text_byte; adv_ch1 = ";";
      end else begin
        adv_n = 2'd2; adv_ch0 = "!"; adv_ch1 = ";";
      end
    end
  end

  // Build the run; a rejected string emits nothing until its terminator.
  always_comb begin
    logic [1:0] n;
    n = rejected ? 2'd0 : adv_n;
    run.ch0     = adv_ch0;
    run.ch1     = adv_ch1;
    run.two     = (n == 2'd2);
    run.hc0     = (n != 2'd0);
    run.str_end = is_end;
    run.acc     = is_end & ~rejected;
    run_valid   = take & ((n != 2'd0) | is_end);
  end

  always_comb begin
    phase_next    = phase;
    rejected_next = rejected;
    if (take) begin
      if (is_end) begin
        phase_next    = PH_TEXT;
        rejected_next = 1'b0;
      end else if (!rejected) begin
        phase_next    = adv_phase;
        rejected_next = adv_rej;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TEXT;
      rejected <= 1'b0;
    end else begin
      phase    <= phase_next;
      rejected <= rejected_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pfss_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfss_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire pfss_pkg::run_t  wr_data,
  output logic                 q_full,
  output logic                 q_valid,
  input  wire logic            rd_en,
  output pfss_pkg::run_t       rd_data
);
  import pfss_pkg::*;

  run_t              slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slot[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pfss_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfss_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire pfss_pkg::run_t  q_data,
  output logic                 q_pop,
  input  wire logic            pop,
  output logic                 empty,
  output logic [7:0]           sig_char,
  output logic                 has_char,
  output logic                 string_end,
  output logic                 accepted,
  output logic                 last_of_run
);
  import pfss_pkg::*;

  run_t cur;
  logic out_valid;
  logic idx;
  logic last;
  logic word_done;

  assign last      = ~cur.two | idx;
  assign word_done = out_valid & pop;
  // Load the next run when the holding register frees up.
  assign q_pop     = q_valid & (~out_valid | (word_done & last));

  assign empty       = ~out_valid;
  assign sig_char    = idx ? cur.ch1 : cur.ch0;
  assign has_char    = idx | cur.hc0;
  assign string_end  = cur.str_end & last;
  assign accepted    = cur.acc & last;
  assign last_of_run = last;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
      idx       <= 1'b0;
    end else if (word_done) begin
      if (last) begin
        out_valid <= 1'b0;
        idx       <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

  a_nochar_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> string_end)
    else $error("word without character that does not end the string");

  a_acc_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> string_end && last_of_run)
    else $error("accepted flag outside a string end");

  a_second_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && pop && !last |=> out_valid && idx && $stable(cur))
    else $error("second word of a run lost");

  a_idx_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && idx |-> cur.two)
    else $error("second word of a one-word run");

endmodule

`default_nettype wire

[hw/rtl/printf_format_signature_scanner_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake     | Word
// ---------+---------------+--------------------------------------------------
// input    | push / full   | text_byte
// result   | pop / empty   | sig_char, has_char, string_end, accepted,
//          |               | last_of_run
//
// One text byte is taken per cycle while full is low; the phase machine settles
// it in that cycle. A byte gives zero, one or two result words; the back end
// sends one word per cycle while pop is high, so two-word bytes hold it longer.
// A four-run queue between front and back absorbs those bursts; full rises
// only when the queue holds four runs.
// rst clears the phase, the reject flag, the queue count and output valid flag.

module printf_format_signature_scanner_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] text_byte,
  input  wire logic       push,
  output logic            full,
  output logic [7:0]      sig_char,
  output logic            has_char,
  output logic            string_end,
  output logic            accepted,
  output logic            last_of_run,
  output logic            empty,
  input  wire logic       pop
);
  import pfss_pkg::*;

  logic take;
  logic run_valid;
  run_t run;
  logic q_full;
  logic q_valid;
  logic q_pop;
  run_t q_data;

  assign full = q_full;
  assign take = push & ~q_full;

  pfss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text_byte),
    .take      (take),
    .run_valid (run_valid),
    .run       (run)
  );

  pfss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (run_valid),
    .wr_data (run),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_en   (q_pop),
    .rd_data (q_data)
  );

  pfss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .sig_char    (sig_char),
    .has_char    (has_char),
    .string_end  (string_end),
    .accepted    (accepted),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
